// ----- hw/rtl/vbrl_pkg.sv -----
package vbrl_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DESIRED_GAIN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_GAIN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACCELERATION = 2'd2;

   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_DATA_W-1:0] CSR_RESET_VALUE = 16'd256;

   localparam int WEIGHT_W = 16;
   localparam int SPEED_W  = 15;
   localparam int DT_W     = 16;

   // depth of the queue between front and back, and of the result queue
   localparam int QUEUE_DEPTH = 4;

endpackage

// ----- hw/rtl/velocity_blend_rate_limiter_top.sv -----
// Velocity blend and rate limiter.
// Input queue port: push an item (desired and previous velocity, speed limit,
// time step) when req_full is low. Result queue port: the limited velocity
// is on rsp_out_vx/rsp_out_vy while rsp_empty is low; pop takes the beat.
// Config port: csr_we writes csr_wdata to goal weight, smooth weight or max
// acceleration (index 0..2); other indexes are dropped. Write only when idle.
// One item per cycle sustained while the receiver keeps popping. Items pass through
// three pipelines: the blend (VEL_WIDTH+3 stages, most of them its divider), the
// step clamp and the speed clamp (each 2*min(width,31)+7 stages for its square root
// and two dividers), with one queue after the blend and one at the output.
// Reset empties both queues and all pipelines and sets each register to 1.0.
// When the receiver stops popping, the result queue fills, the back pipeline
// holds, the middle queue fills, the front holds and req_full rises; no beat
// is lost.
module velocity_blend_rate_limiter_top #(
   parameter int VEL_WIDTH     = 16,
   parameter int VEL_FRAC_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [VEL_WIDTH-1:0]         req_desired_vx,
   input  logic signed [VEL_WIDTH-1:0]         req_desired_vy,
   input  logic signed [VEL_WIDTH-1:0]         req_prev_vx,
   input  logic signed [VEL_WIDTH-1:0]         req_prev_vy,
   input  logic [vbrl_pkg::SPEED_W-1:0]        req_speed_limit,
   input  logic [vbrl_pkg::DT_W-1:0]           req_time_step,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [VEL_WIDTH-1:0]         rsp_out_vx,
   output logic signed [VEL_WIDTH-1:0]         rsp_out_vy,
   input  logic                                csr_we,
   input  logic [vbrl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vbrl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int W      = VEL_WIDTH;
   localparam int LW     = VEL_FRAC_BITS + 8;
   localparam int SIDE_W = 2 * W + LW;

   typedef struct packed {
      logic signed [W-1:0] bx;
      logic signed [W-1:0] by;
      logic signed [W-1:0] px;
      logic signed [W-1:0] py;
      logic [LW-1:0]       step_lim;
      logic [LW-1:0]       speed_lim;
   } mid_type;

   logic [vbrl_pkg::WEIGHT_W-1:0] desired_gain_ff;
   logic [vbrl_pkg::WEIGHT_W-1:0] history_gain_ff;
   logic [vbrl_pkg::WEIGHT_W-1:0] max_accel_ff;

   logic                en_f;
   logic                en_b;
   logic                bl_valid;
   mid_type             bl_beat;
   logic                mid_full;
   logic                mid_empty;
   mid_type             mid_beat;
   logic                mid_pop;

   logic signed [W:0]   st_in_x;
   logic signed [W:0]   st_in_y;
   logic                st_valid;
   logic signed [W:0]   st_x;
   logic signed [W:0]   st_y;
   logic [SIDE_W-1:0]   st_side;
   logic signed [W-1:0] st_px;
   logic signed [W-1:0] st_py;
   logic [LW-1:0]       st_speed_lim;
   logic signed [W-1:0] sp_in_x;
   logic signed [W-1:0] sp_in_y;

   logic                sp_valid;
   logic signed [W-1:0] sp_x;
   logic signed [W-1:0] sp_y;
   logic                out_full;
   logic [2*W-1:0]      out_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         desired_gain_ff <= vbrl_pkg::CSR_RESET_VALUE;
         history_gain_ff <= vbrl_pkg::CSR_RESET_VALUE;
         max_accel_ff    <= vbrl_pkg::CSR_RESET_VALUE;
      end else if (csr_we) begin
         case (csr_index)
            vbrl_pkg::CSR_DESIRED_GAIN:     desired_gain_ff <= csr_wdata;
            vbrl_pkg::CSR_HISTORY_GAIN:     history_gain_ff <= csr_wdata;
            vbrl_pkg::CSR_MAX_ACCELERATION: max_accel_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: hold while its last stage cannot drain into the middle queue
   assign en_f     = !bl_valid || !mid_full;
   assign req_full = !en_f;

   vbrl_blend #(
      .VEL_WIDTH     (VEL_WIDTH),
      .VEL_FRAC_BITS (VEL_FRAC_BITS)
   ) u_blend (
      .clock            (clock),
      .reset            (reset),
      .en               (en_f),
      .in_valid         (req_push),
      .dx               (req_desired_vx),
      .dy               (req_desired_vy),
      .px               (req_prev_vx),
      .py               (req_prev_vy),
      .speed_limit      (req_speed_limit),
      .time_step        (req_time_step),
      .desired_gain     (desired_gain_ff),
      .history_gain     (history_gain_ff),
      .max_acceleration (max_accel_ff),
      .out_valid        (bl_valid),
      .bx               (bl_beat.bx),
      .by               (bl_beat.by),
      .out_px           (bl_beat.px),
      .out_py           (bl_beat.py),
      .step_lim         (bl_beat.step_lim),
      .speed_lim        (bl_beat.speed_lim)
   );

   vbrl_fifo #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (vbrl_pkg::QUEUE_DEPTH)
   ) u_mid_q (
      .clock   (clock),
      .reset   (reset),
      .push    (bl_valid),
      .wr_data (bl_beat),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (mid_beat),
      .empty   (mid_empty)
   );

   // back: both clamps advance together, held only by the result queue
   assign en_b    = !sp_valid || !out_full;
   assign mid_pop = en_b && !mid_empty;

   assign st_in_x = (W+1)'(mid_beat.bx) - (W+1)'(mid_beat.px);
   assign st_in_y = (W+1)'(mid_beat.by) - (W+1)'(mid_beat.py);

   vbrl_clamp #(
      .IN_W   (W + 1),
      .LIM_W  (LW),
      .SIDE_W (SIDE_W)
   ) u_step_clamp (
      .clock     (clock),
      .reset     (reset),
      .en        (en_b),
      .in_valid  (!mid_empty),
      .in_x      (st_in_x),
      .in_y      (st_in_y),
      .in_lim    (mid_beat.step_lim),
      .in_side   ({mid_beat.px, mid_beat.py, mid_beat.speed_lim}),
      .out_valid (st_valid),
      .out_x     (st_x),
      .out_y     (st_y),
      .out_side  (st_side)
   );

   assign st_px        = st_side[SIDE_W-1 -: W];
   assign st_py        = st_side[LW+W-1 -: W];
   assign st_speed_lim = st_side[LW-1:0];

   // limited step stays between previous and blended velocity, so it fits
   assign sp_in_x = W'((W+1)'(st_px) + st_x);
   assign sp_in_y = W'((W+1)'(st_py) + st_y);

   vbrl_clamp #(
      .IN_W   (W),
      .LIM_W  (LW),
      .SIDE_W (1)
   ) u_speed_clamp (
      .clock     (clock),
      .reset     (reset),
      .en        (en_b),
      .in_valid  (st_valid),
      .in_x      (sp_in_x),
      .in_y      (sp_in_y),
      .in_lim    (st_speed_lim),
      .in_side   (1'b0),
      .out_valid (sp_valid),
      .out_x     (sp_x),
      .out_y     (sp_y),
      .out_side  ()
   );

   vbrl_fifo #(
      .WIDTH (2 * W),
      .DEPTH (vbrl_pkg::QUEUE_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (sp_valid),
      .wr_data ({sp_x, sp_y}),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (out_beat),
      .empty   (rsp_empty)
   );

   assign rsp_out_vx = $signed(out_beat[2*W-1:W]);
   assign rsp_out_vy = $signed(out_beat[W-1:0]);

endmodule

// ----- hw/rtl/vbrl_fifo.sv -----
module vbrl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW:0]      count_ff;
   logic             push_ok;
   logic             pop_ok;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- hw/rtl/vbrl_blend.sv -----
module vbrl_blend #(
   parameter int VEL_WIDTH     = 16,
   parameter int VEL_FRAC_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [VEL_WIDTH-1:0]   dx,
   input  logic signed [VEL_WIDTH-1:0]   dy,
   input  logic signed [VEL_WIDTH-1:0]   px,
   input  logic signed [VEL_WIDTH-1:0]   py,
   input  logic [vbrl_pkg::SPEED_W-1:0]  speed_limit,
   input  logic [vbrl_pkg::DT_W-1:0]     time_step,
   input  logic [vbrl_pkg::WEIGHT_W-1:0] desired_gain,
   input  logic [vbrl_pkg::WEIGHT_W-1:0] history_gain,
   input  logic [vbrl_pkg::WEIGHT_W-1:0] max_acceleration,
   output logic                          out_valid,
   output logic signed [VEL_WIDTH-1:0]   bx,
   output logic signed [VEL_WIDTH-1:0]   by,
   output logic signed [VEL_WIDTH-1:0]   out_px,
   output logic signed [VEL_WIDTH-1:0]   out_py,
   output logic [VEL_FRAC_BITS+7:0]      step_lim,
   output logic [VEL_FRAC_BITS+7:0]      speed_lim
);

   localparam int W    = VEL_WIDTH;
   localparam int LW   = VEL_FRAC_BITS + 8;
   localparam int WSW  = vbrl_pkg::WEIGHT_W + 1;
   localparam int PW   = W + WSW;
   localparam int MAGW = PW + 1;
   localparam int TW   = VEL_FRAC_BITS + 16;
   localparam int PRDW = vbrl_pkg::WEIGHT_W + vbrl_pkg::DT_W;
   localparam int NSB  = W + 3;

   typedef struct packed {
      logic signed [W-1:0]  dx;
      logic signed [W-1:0]  dy;
      logic signed [W-1:0]  px;
      logic signed [W-1:0]  py;
      logic [LW-1:0]        step_lim;
      logic [LW-1:0]        speed_lim;
      logic [WSW-1:0]       wsum;
      logic signed [PW-1:0] gdx;
      logic signed [PW-1:0] spx;
      logic signed [PW-1:0] gdy;
      logic signed [PW-1:0] spy;
      logic                 negx;
      logic                 negy;
      logic [MAGW-1:0]      remx;
      logic [MAGW-1:0]      remy;
      logic [W-1:0]         qx;
      logic [W-1:0]         qy;
      logic signed [W-1:0]  bx;
      logic signed [W-1:0]  by;
   } bs_type;

   bs_type         stage_in [NSB];
   bs_type         stage_ff [NSB];
   logic [NSB-1:0] vld_ff;

   genvar j;
   generate
      for (j = 0; j < NSB; j++) begin : g_stage
         if (j == 0) begin : g_mul
            // weight products, limits
            always_comb begin
               logic [PRDW-1:0] accdt;
               logic [TW-1:0]   sl_ext;
               bs_type          p;
               accdt  = PRDW'(max_acceleration) * PRDW'(time_step);
               sl_ext = TW'(speed_limit) << VEL_FRAC_BITS;
               p           = '0;
               p.dx        = dx;
               p.dy        = dy;
               p.px        = px;
               p.py        = py;
               p.wsum      = WSW'(desired_gain) + WSW'(history_gain);
               p.step_lim  = accdt[PRDW-1:PRDW-LW];
               p.speed_lim = sl_ext[TW-1:8];
               p.gdx = PW'($signed({1'b0, desired_gain})) * PW'(dx);
               p.spx = PW'($signed({1'b0, history_gain})) * PW'(px);
               p.gdy = PW'($signed({1'b0, desired_gain})) * PW'(dy);
               p.spy = PW'($signed({1'b0, history_gain})) * PW'(py);
               stage_in[j] = p;
            end
         end else if (j == 1) begin : g_sum
            always_comb begin
               logic signed [PW:0] numx;
               logic signed [PW:0] numy;
               bs_type             p;
               p    = stage_ff[j-1];
               numx = (PW+1)'(p.gdx) + (PW+1)'(p.spx);
               numy = (PW+1)'(p.gdy) + (PW+1)'(p.spy);
               p.negx = numx[PW];
               p.negy = numy[PW];
               // magnitude plus half the divisor: round half away from zero
               p.remx = (p.negx ? MAGW'(-numx) : MAGW'(numx)) + MAGW'(p.wsum >> 1);
               p.remy = (p.negy ? MAGW'(-numy) : MAGW'(numy)) + MAGW'(p.wsum >> 1);
               p.qx   = '0;
               p.qy   = '0;
               stage_in[j] = p;
            end
         end else if (j < W + 2) begin : g_div
            localparam int B = W + 1 - j;
            always_comb begin
               logic [MAGW-1:0] trial;
               bs_type          p;
               p     = stage_ff[j-1];
               trial = MAGW'(p.wsum) << B;
               if (p.remx >= trial) begin
                  p.remx  = p.remx - trial;
                  p.qx[B] = 1'b1;
               end
               if (p.remy >= trial) begin
                  p.remy  = p.remy - trial;
                  p.qy[B] = 1'b1;
               end
               stage_in[j] = p;
            end
         end else begin : g_sign
            always_comb begin
               bs_type p;
               p = stage_ff[j-1];
               if (p.wsum == '0) begin
                  // both weights off: pass desired velocity
                  p.bx = p.dx;
                  p.by = p.dy;
               end else begin
                  p.bx = $signed(p.negx ? (~p.qx + 1'b1) : p.qx);
                  p.by = $signed(p.negy ? (~p.qy + 1'b1) : p.qy);
               end
               stage_in[j] = p;
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSB-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[NSB-1];
   assign bx        = stage_ff[NSB-1].bx;
   assign by        = stage_ff[NSB-1].by;
   assign out_px    = stage_ff[NSB-1].px;
   assign out_py    = stage_ff[NSB-1].py;
   assign step_lim  = stage_ff[NSB-1].step_lim;
   assign speed_lim = stage_ff[NSB-1].speed_lim;

endmodule

// ----- hw/rtl/vbrl_clamp.sv -----
module vbrl_clamp #(
   parameter int IN_W   = 17,
   parameter int LIM_W  = 16,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [IN_W-1:0]   in_x,
   input  logic signed [IN_W-1:0]   in_y,
   input  logic [LIM_W-1:0]         in_lim,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic signed [IN_W-1:0]   out_x,
   output logic signed [IN_W-1:0]   out_y,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int CW   = (IN_W > 31) ? 31 : IN_W;
   localparam int SMAX = IN_W - CW;
   localparam int NW   = CW + 1;
   localparam int N2W  = 2 * NW;
   localparam int RW   = NW + 3;
   localparam int PRW  = CW + LIM_W;
   localparam int DW   = CW + ((LIM_W > NW) ? LIM_W : NW);
   localparam int CMPW = (N2W > 2 * LIM_W) ? N2W : 2 * LIM_W;
   localparam int SQRT0 = 4;
   localparam int CEILS = SQRT0 + NW;
   localparam int DIV0  = CEILS + 1;
   localparam int FINS  = DIV0 + CW;
   localparam int NST   = FINS + 1;

   typedef struct packed {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic                   nx;
      logic                   ny;
      logic [IN_W-1:0]        ax;
      logic [IN_W-1:0]        ay;
      logic [1:0]             s;
      logic [CW-1:0]          sx;
      logic [CW-1:0]          sy;
      logic [LIM_W-1:0]       ls;
      logic [2*CW-1:0]        sqx;
      logic [2*CW-1:0]        sqy;
      logic [2*LIM_W-1:0]     lsq;
      logic [PRW-1:0]         prx;
      logic [PRW-1:0]         pry;
      logic [N2W-1:0]         n2;
      logic                   pass;
      logic [NW-1:0]          root;
      logic [RW-1:0]          srem;
      logic [NW-1:0]          n;
      logic [DW-1:0]          drx;
      logic [DW-1:0]          dry;
      logic [CW-1:0]          qx;
      logic [CW-1:0]          qy;
      logic [SIDE_W-1:0]      side;
   } cs_type;

   cs_type         stage_in [NST];
   cs_type         stage_ff [NST];
   logic [NST-1:0] vld_ff;

   genvar j;
   generate
      for (j = 0; j < NST; j++) begin : g_stage
         if (j == 0) begin : g_abs
            always_comb begin
               cs_type p;
               p      = '0;
               p.x    = in_x;
               p.y    = in_y;
               p.nx   = in_x[IN_W-1];
               p.ny   = in_y[IN_W-1];
               p.ax   = p.nx ? IN_W'(-in_x) : IN_W'(in_x);
               p.ay   = p.ny ? IN_W'(-in_y) : IN_W'(in_y);
               p.ls   = in_lim;
               p.side = in_side;
               stage_in[j] = p;
            end
         end else if (j == 1) begin : g_shift
            // pre-shift very wide vectors so each magnitude stays below 2^31
            always_comb begin
               cs_type p;
               p   = stage_ff[j-1];
               p.s = '0;
               for (int i = SMAX; i >= 0; i--) begin
                  if (((p.ax >> i) >> CW) == '0 && ((p.ay >> i) >> CW) == '0) begin
                     p.s = 2'(i);
                  end
               end
               p.sx = CW'(p.ax >> p.s);
               p.sy = CW'(p.ay >> p.s);
               p.ls = p.ls >> p.s;
               stage_in[j] = p;
            end
         end else if (j == 2) begin : g_mul
            always_comb begin
               cs_type p;
               p     = stage_ff[j-1];
               p.sqx = (2*CW)'(p.sx) * (2*CW)'(p.sx);
               p.sqy = (2*CW)'(p.sy) * (2*CW)'(p.sy);
               p.lsq = (2*LIM_W)'(p.ls) * (2*LIM_W)'(p.ls);
               p.prx = PRW'(p.sx) * PRW'(p.ls);
               p.pry = PRW'(p.sy) * PRW'(p.ls);
               stage_in[j] = p;
            end
         end else if (j == 3) begin : g_test
            always_comb begin
               cs_type p;
               p      = stage_ff[j-1];
               p.n2   = N2W'(p.sqx) + N2W'(p.sqy);
               // zero vector always passes here
               p.pass = CMPW'(p.n2) <= CMPW'(p.lsq);
               p.root = '0;
               p.srem = '0;
               stage_in[j] = p;
            end
         end else if (j < CEILS) begin : g_sqrt
            localparam int PB = 2 * (NW - 1 - (j - SQRT0));
            always_comb begin
               logic [RW-1:0] cur;
               logic [RW-1:0] trial;
               cs_type        p;
               p     = stage_ff[j-1];
               cur   = {p.srem[RW-3:0], p.n2[PB+1:PB]};
               trial = RW'({p.root, 2'b01});
               if (cur >= trial) begin
                  p.srem = cur - trial;
                  p.root = {p.root[NW-2:0], 1'b1};
               end else begin
                  p.srem = cur;
                  p.root = {p.root[NW-2:0], 1'b0};
               end
               stage_in[j] = p;
            end
         end else if (j == CEILS) begin : g_ceil
            always_comb begin
               cs_type p;
               p     = stage_ff[j-1];
               p.n   = p.root + NW'(p.srem != '0);
               p.drx = DW'(p.prx);
               p.dry = DW'(p.pry);
               p.qx  = '0;
               p.qy  = '0;
               stage_in[j] = p;
            end
         end else if (j < FINS) begin : g_div
            localparam int B = CW - 1 - (j - DIV0);
            always_comb begin
               logic [DW-1:0] trial;
               cs_type        p;
               p     = stage_ff[j-1];
               trial = DW'(p.n) << B;
               if (p.drx >= trial) begin
                  p.drx   = p.drx - trial;
                  p.qx[B] = 1'b1;
               end
               if (p.dry >= trial) begin
                  p.dry   = p.dry - trial;
                  p.qy[B] = 1'b1;
               end
               stage_in[j] = p;
            end
         end else begin : g_out
            always_comb begin
               logic [IN_W-1:0] rx;
               logic [IN_W-1:0] ry;
               cs_type          p;
               p  = stage_ff[j-1];
               rx = IN_W'(p.qx) << p.s;
               ry = IN_W'(p.qy) << p.s;
               if (!p.pass) begin
                  p.x = $signed(p.nx ? (~rx + 1'b1) : rx);
                  p.y = $signed(p.ny ? (~ry + 1'b1) : ry);
               end
               stage_in[j] = p;
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_x     = stage_ff[NST-1].x;
   assign out_y     = stage_ff[NST-1].y;
   assign out_side  = stage_ff[NST-1].side;

endmodule

// ----- hw/rtl/vbrl_checker.sv -----
module vbrl_checker #(
   parameter int VEL_WIDTH = 16
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_full,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic signed [VEL_WIDTH-1:0] rsp_out_vx,
   input logic signed [VEL_WIDTH-1:0] rsp_out_vy
);

   // reset leaves nothing queued and the input open
   a_reset_idle: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full ##1 rsp_empty)
      else $error("queues not idle after reset");

   // a waiting result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_vx) && $stable(rsp_out_vy))
      else $error("result beat changed while stalled");

   // the input only backs up while results wait in the result queue
   a_full_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> !rsp_empty)
      else $error("input stalled with empty result queue");

endmodule

bind velocity_blend_rate_limiter_top vbrl_checker #(.VEL_WIDTH(VEL_WIDTH)) u_vbrl_checker (.*);
